// File: hw/rtl/weighted_line_fit_assert.svh
// Assertion macros shared by the weighted line fit RTL.
`ifndef WEIGHTED_LINE_FIT_ASSERT_SVH
`define WEIGHTED_LINE_FIT_ASSERT_SVH

`define WLF_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`define WLF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`define WLF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/wlf_pkg.sv
// Package with widths, codes and helper functions of the weighted line fit.
package wlf_pkg;

  localparam int MAX_POINTS_DEF = 16;
  localparam int COORD_W = 24;
  localparam int ERR_W = 16;
  localparam int CFG_W = 16;
  localparam int W_W = 40;
  localparam int ACC_W = 128;
  localparam int MUL_BW = 40;
  localparam int RES_W = 32;
  localparam int STAT_W = 2;
  localparam int DIV_CW = $clog2(ACC_W + 1);
  localparam int MUL_CW = $clog2(MUL_BW + 1);
  localparam int SLOPE_SHIFT = 20;

  localparam logic [0:0] CFG_ERROR_FLOOR = 1'b0;
  localparam logic [0:0] CFG_ERROR_SUBST = 1'b1;

  localparam logic [STAT_W-1:0] STAT_OK = 2'd0;
  localparam logic [STAT_W-1:0] STAT_DEGEN = 2'd1;
  localparam logic [STAT_W-1:0] STAT_OVFL = 2'd2;

  localparam logic [CFG_W-1:0] FLOOR_RST = 16'd1;
  localparam logic [CFG_W-1:0] SUBST_RST = 16'd10000;

  localparam logic [ACC_W-1:0] WNUM_ALIGNED = {{W_W{1'b1}}, {(ACC_W - W_W){1'b0}}};

  function automatic logic [RES_W-1:0] sat32(input logic [ACC_W-1:0] v);
    logic [ACC_W-RES_W:0] hi;
    hi = v[ACC_W-1:RES_W-1];
    if ((hi == '0) || (hi == '1)) begin
      return v[RES_W-1:0];
    end else if (v[ACC_W-1]) begin
      return {1'b1, {(RES_W - 1){1'b0}}};
    end else begin
      return {1'b0, {(RES_W - 1){1'b1}}};
    end
  endfunction

  function automatic logic [ACC_W-1:0] round_q(input logic [ACC_W-1:0] q,
                                               input logic [ACC_W-1:0] rem,
                                               input logic [ACC_W-1:0] den,
                                               input logic neg);
    logic [ACC_W-1:0] m;
    m = q + ACC_W'(({rem, 1'b0} >= {1'b0, den}) ? 1 : 0);
    return neg ? (~m + ACC_W'(1)) : m;
  endfunction

endpackage

// File: hw/rtl/wlf_divider.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module wlf_divider (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [wlf_pkg::ACC_W-1:0]   num,
  input  logic [wlf_pkg::ACC_W-1:0]   den,
  input  logic [wlf_pkg::DIV_CW-1:0]  steps,
  output logic                        done,
  output logic [wlf_pkg::ACC_W-1:0]   quo,
  output logic [wlf_pkg::ACC_W-1:0]   rem
);
  import wlf_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [DIV_CW-1:0] cnt_r;
  logic [ACC_W-1:0]  num_r;
  logic [ACC_W-1:0]  den_r;
  logic [ACC_W:0]    rem_r;
  logic [ACC_W-1:0]  quo_r;
  logic [ACC_W:0]    trial;
  logic              ge;

  assign trial = {rem_r[ACC_W-1:0], num_r[ACC_W-1]};
  assign ge = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r <= steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - DIV_CW'(1);
        if (cnt_r == DIV_CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? (trial - {1'b0, den_r}) : trial;
      quo_r <= {quo_r[ACC_W-2:0], ge};
      num_r <= {num_r[ACC_W-2:0], 1'b0};
    end
  end

  assign done = done_r;
  assign quo = quo_r;
  assign rem = rem_r[ACC_W-1:0];

endmodule

// File: hw/rtl/wlf_serial_mul.sv
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
module wlf_serial_mul (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [wlf_pkg::ACC_W-1:0]   a,
  input  logic [wlf_pkg::MUL_BW-1:0]  b,
  input  logic [wlf_pkg::MUL_CW-1:0]  steps,
  output logic                        done,
  output logic [wlf_pkg::ACC_W-1:0]   prod
);
  import wlf_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [MUL_CW-1:0] cnt_r;
  logic [ACC_W-1:0]  a_r;
  logic [MUL_BW-1:0] b_r;
  logic [ACC_W-1:0]  acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r <= steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - MUL_CW'(1);
        if (cnt_r == MUL_CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
      acc_r <= '0;
    end else if (busy_r) begin
      if (b_r[0]) begin
        acc_r <= acc_r + a_r;
      end
      a_r <= {a_r[ACC_W-2:0], 1'b0};
      b_r <= {1'b0, b_r[MUL_BW-1:1]};
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

// File: hw/rtl/weighted_line_fit.sv
// Weighted least-squares straight-line fit with bit-serial divide and multiply.
// A stored point runs a weight division before the next point can be accepted; a dropped
// point (store full) skips it. A last point adds the fit: a weighted-sum pass over the points,
// two mean divisions, a variance pass over the points, then the slope division and the
// intercept multiply and divide.
// Reset is synchronous: it empties the point store, clears the flags and loads the error registers.
module weighted_line_fit #(
  parameter int MAX_POINTS = wlf_pkg::MAX_POINTS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [63:0]               in_tdata,   // pos_z[23:0], pos_t[47:24], pos_err[63:48]
  input  logic                      in_tlast,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [71:0]               out_tdata,  // intercept[31:0], slope[63:32], fit_status[65:64]
  input  logic                      cfg_we,
  input  logic [0:0]                cfg_addr,
  input  logic [wlf_pkg::CFG_W-1:0] cfg_wdata
);
  import wlf_pkg::*;

  `include "weighted_line_fit_assert.svh"

  localparam int PTR_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int MEM_W = W_W + 2 * COORD_W;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_WGO    = 5'd1;
  localparam logic [4:0] S_WWT    = 5'd2;
  localparam logic [4:0] S_CHECK  = 5'd3;
  localparam logic [4:0] S_P1RD   = 5'd4;
  localparam logic [4:0] S_P1ZGO  = 5'd5;
  localparam logic [4:0] S_P1ZWT  = 5'd6;
  localparam logic [4:0] S_P1TGO  = 5'd7;
  localparam logic [4:0] S_P1TWT  = 5'd8;
  localparam logic [4:0] S_MZGO   = 5'd9;
  localparam logic [4:0] S_MZWT   = 5'd10;
  localparam logic [4:0] S_MTGO   = 5'd11;
  localparam logic [4:0] S_MTWT   = 5'd12;
  localparam logic [4:0] S_P2RD   = 5'd13;
  localparam logic [4:0] S_P2DGO  = 5'd14;
  localparam logic [4:0] S_P2DWT  = 5'd15;
  localparam logic [4:0] S_P2ZZGO = 5'd16;
  localparam logic [4:0] S_P2ZZWT = 5'd17;
  localparam logic [4:0] S_P2TGO  = 5'd18;
  localparam logic [4:0] S_P2TWT  = 5'd19;
  localparam logic [4:0] S_P2ZTGO = 5'd20;
  localparam logic [4:0] S_P2ZTWT = 5'd21;
  localparam logic [4:0] S_FIN    = 5'd22;
  localparam logic [4:0] S_SLGO   = 5'd23;
  localparam logic [4:0] S_SLWT   = 5'd24;
  localparam logic [4:0] S_IPMGO  = 5'd25;
  localparam logic [4:0] S_IPMWT  = 5'd26;
  localparam logic [4:0] S_IPDGO  = 5'd27;
  localparam logic [4:0] S_IPDWT  = 5'd28;
  localparam logic [4:0] S_OUT    = 5'd29;

  logic [4:0]       state_r, state_nxt;
  logic [CFG_W-1:0] floor_r, subst_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ovf_r, ovf_nxt;
  logic [PTR_W-1:0] idx_r, idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [71:0]      out_data_r, out_data_nxt;

  logic [COORD_W-1:0] z_r, t_r;
  logic               last_r;
  logic [2*ERR_W-1:0] e2_r;
  logic [ERR_W-1:0]   e_sel, e_eff;

  logic [MEM_W-1:0] mem [MAX_POINTS];
  logic [MEM_W-1:0] rd_q_r;
  logic             mem_we;

  logic [ACC_W-1:0] sw_r, swz_r, swt_r, szz_r, szt_r, tmp_r;
  logic [ACC_W-1:0] sw_nxt, swz_nxt, swt_nxt, szz_nxt, szt_nxt, tmp_nxt;
  logic [COORD_W-1:0] zm_r, tm_r, zm_nxt, tm_nxt;
  logic             div_neg_r, div_neg_nxt;
  logic [RES_W-1:0] icpt_r, slope_r, icpt_nxt, slope_nxt;
  logic [STAT_W-1:0] stat_r, stat_nxt;

  logic             div_start, div_done;
  logic [ACC_W-1:0] div_num, div_den, div_quo, div_rem;
  logic [DIV_CW-1:0] div_steps;
  logic             mul_start, mul_done;
  logic [ACC_W-1:0] mul_a, mul_p;
  logic [MUL_BW-1:0] mul_b;
  logic [MUL_CW-1:0] mul_steps;

  logic [COORD_W-1:0] rd_z, rd_t;
  logic [W_W-1:0]     rd_w;
  logic [COORD_W:0]   z_mag, t_mag, dz, dt, dz_mag, dt_mag, zm_mag;
  logic [ACC_W-1:0]   swz_mag, swt_mag, szt_mag, rq, mul_sgn;
  logic               accept, last_idx;

  assign rd_z = rd_q_r[COORD_W-1:0];
  assign rd_t = rd_q_r[2*COORD_W-1:COORD_W];
  assign rd_w = rd_q_r[MEM_W-1:2*COORD_W];

  assign z_mag = rd_z[COORD_W-1] ? (~{1'b1, rd_z} + 1'b1) : {1'b0, rd_z};
  assign t_mag = rd_t[COORD_W-1] ? (~{1'b1, rd_t} + 1'b1) : {1'b0, rd_t};
  assign zm_mag = zm_r[COORD_W-1] ? (~{1'b1, zm_r} + 1'b1) : {1'b0, zm_r};
  assign dz = {rd_z[COORD_W-1], rd_z} - {zm_r[COORD_W-1], zm_r};
  assign dt = {rd_t[COORD_W-1], rd_t} - {tm_r[COORD_W-1], tm_r};
  assign dz_mag = dz[COORD_W] ? (~dz + 1'b1) : dz;
  assign dt_mag = dt[COORD_W] ? (~dt + 1'b1) : dt;
  assign swz_mag = swz_r[ACC_W-1] ? (~swz_r + 1'b1) : swz_r;
  assign swt_mag = swt_r[ACC_W-1] ? (~swt_r + 1'b1) : swt_r;
  assign szt_mag = szt_r[ACC_W-1] ? (~szt_r + 1'b1) : szt_r;
  assign rq = round_q(div_quo, div_rem, div_den, div_neg_r);
  assign last_idx = ((CNT_W'(idx_r) + CNT_W'(1)) == cnt_r);

  assign e_sel = (in_tdata[63:48] < floor_r) ? subst_r : in_tdata[63:48];
  assign e_eff = (e_sel == '0) ? ERR_W'(1) : e_sel;

  assign accept = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign mem_we = (state_r == S_WWT) && div_done;

  wlf_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .steps (div_steps),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  wlf_serial_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .steps (mul_steps),
    .done  (mul_done),
    .prod  (mul_p)
  );

  always_comb begin
    div_start = 1'b0;
    div_num = swz_mag;
    div_den = sw_r;
    div_steps = DIV_CW'(ACC_W);
    div_neg_nxt = div_neg_r;
    case (state_r)
      S_WGO: begin
        div_start = 1'b1;
        div_num = WNUM_ALIGNED;
        div_den = ACC_W'(e2_r);
        div_steps = DIV_CW'(W_W);
        div_neg_nxt = 1'b0;
      end
      S_MZGO: begin
        div_start = 1'b1;
        div_neg_nxt = swz_r[ACC_W-1];
      end
      S_MTGO: begin
        div_start = 1'b1;
        div_num = swt_mag;
        div_neg_nxt = swt_r[ACC_W-1];
      end
      S_SLGO, S_SLWT: begin
        div_start = (state_r == S_SLGO);
        div_num = szt_mag << SLOPE_SHIFT;
        div_den = szz_r;
        if (state_r == S_SLGO) begin
          div_neg_nxt = szt_r[ACC_W-1];
        end
      end
      S_IPDGO, S_IPDWT: begin
        div_start = (state_r == S_IPDGO);
        div_num = tmp_r;
        div_den = szz_r;
        if (state_r == S_IPDGO) begin
          div_neg_nxt = szt_r[ACC_W-1] ^ zm_r[COORD_W-1];
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    mul_start = 1'b0;
    mul_a = ACC_W'(rd_w);
    mul_b = MUL_BW'(z_mag);
    mul_steps = MUL_CW'(COORD_W + 1);
    case (state_r)
      S_P1ZGO: begin
        mul_start = 1'b1;
      end
      S_P1TGO: begin
        mul_start = 1'b1;
        mul_b = MUL_BW'(t_mag);
      end
      S_P2DGO: begin
        mul_start = 1'b1;
        mul_a = ACC_W'(dz_mag);
        mul_b = MUL_BW'(dz_mag);
      end
      S_P2TGO: begin
        mul_start = 1'b1;
        mul_a = ACC_W'(dz_mag);
        mul_b = MUL_BW'(dt_mag);
      end
      S_P2ZZGO, S_P2ZTGO: begin
        mul_start = 1'b1;
        mul_a = tmp_r;
        mul_b = MUL_BW'(rd_w);
        mul_steps = MUL_CW'(W_W);
      end
      S_IPMGO: begin
        mul_start = 1'b1;
        mul_a = szt_mag;
        mul_b = MUL_BW'(zm_mag);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    mul_sgn = mul_p;
    case (state_r)
      S_P1ZWT: mul_sgn = rd_z[COORD_W-1] ? (~mul_p + 1'b1) : mul_p;
      S_P1TWT: mul_sgn = rd_t[COORD_W-1] ? (~mul_p + 1'b1) : mul_p;
      S_P2ZTWT: mul_sgn = (dz[COORD_W] ^ dt[COORD_W]) ? (~mul_p + 1'b1) : mul_p;
      default: mul_sgn = mul_p;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    ovf_nxt = ovf_r;
    idx_nxt = idx_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt = out_data_r;
    sw_nxt = sw_r;
    swz_nxt = swz_r;
    swt_nxt = swt_r;
    szz_nxt = szz_r;
    szt_nxt = szt_r;
    tmp_nxt = tmp_r;
    zm_nxt = zm_r;
    tm_nxt = tm_r;
    icpt_nxt = icpt_r;
    slope_nxt = slope_r;
    stat_nxt = stat_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (cnt_r == CNT_W'(MAX_POINTS)) begin
            ovf_nxt = 1'b1;
            state_nxt = S_CHECK;
          end else begin
            state_nxt = S_WGO;
          end
        end
      end
      S_WGO: state_nxt = S_WWT;
      S_WWT: begin
        if (div_done) begin
          cnt_nxt = cnt_r + CNT_W'(1);
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        idx_nxt = '0;
        sw_nxt = '0;
        swz_nxt = '0;
        swt_nxt = '0;
        szz_nxt = '0;
        szt_nxt = '0;
        icpt_nxt = '0;
        slope_nxt = '0;
        stat_nxt = STAT_DEGEN;
        if (!last_r) begin
          state_nxt = S_IDLE;
        end else if (cnt_r == '0) begin
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_P1RD;
        end
      end
      S_P1RD: state_nxt = S_P1ZGO;
      S_P1ZGO: state_nxt = S_P1ZWT;
      S_P1ZWT: begin
        if (mul_done) begin
          swz_nxt = swz_r + mul_sgn;
          sw_nxt = sw_r + ACC_W'(rd_w);
          state_nxt = S_P1TGO;
        end
      end
      S_P1TGO: state_nxt = S_P1TWT;
      S_P1TWT: begin
        if (mul_done) begin
          swt_nxt = swt_r + mul_sgn;
          idx_nxt = idx_r + PTR_W'(1);
          state_nxt = last_idx ? S_MZGO : S_P1RD;
        end
      end
      S_MZGO: state_nxt = S_MZWT;
      S_MZWT: begin
        if (div_done) begin
          zm_nxt = rq[COORD_W-1:0];
          state_nxt = S_MTGO;
        end
      end
      S_MTGO: state_nxt = S_MTWT;
      S_MTWT: begin
        if (div_done) begin
          tm_nxt = rq[COORD_W-1:0];
          idx_nxt = '0;
          state_nxt = S_P2RD;
        end
      end
      S_P2RD: state_nxt = S_P2DGO;
      S_P2DGO: state_nxt = S_P2DWT;
      S_P2DWT: begin
        if (mul_done) begin
          tmp_nxt = mul_p;
          state_nxt = S_P2ZZGO;
        end
      end
      S_P2ZZGO: state_nxt = S_P2ZZWT;
      S_P2ZZWT: begin
        if (mul_done) begin
          szz_nxt = szz_r + mul_p;
          state_nxt = S_P2TGO;
        end
      end
      S_P2TGO: state_nxt = S_P2TWT;
      S_P2TWT: begin
        if (mul_done) begin
          tmp_nxt = mul_p;
          state_nxt = S_P2ZTGO;
        end
      end
      S_P2ZTGO: state_nxt = S_P2ZTWT;
      S_P2ZTWT: begin
        if (mul_done) begin
          szt_nxt = szt_r + mul_sgn;
          idx_nxt = idx_r + PTR_W'(1);
          state_nxt = last_idx ? S_FIN : S_P2RD;
        end
      end
      S_FIN: begin
        state_nxt = (szz_r == '0) ? S_OUT : S_SLGO;
      end
      S_SLGO: state_nxt = S_SLWT;
      S_SLWT: begin
        if (div_done) begin
          slope_nxt = sat32(rq);
          state_nxt = S_IPMGO;
        end
      end
      S_IPMGO: state_nxt = S_IPMWT;
      S_IPMWT: begin
        if (mul_done) begin
          tmp_nxt = mul_p;
          state_nxt = S_IPDGO;
        end
      end
      S_IPDGO: state_nxt = S_IPDWT;
      S_IPDWT: begin
        if (div_done) begin
          icpt_nxt = sat32({{(ACC_W - COORD_W){tm_r[COORD_W-1]}}, tm_r} - rq);
          stat_nxt = ovf_r ? STAT_OVFL : STAT_OK;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt = {6'd0, stat_r, slope_r, icpt_r};
          cnt_nxt = '0;
          ovf_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      ovf_r <= 1'b0;
      out_valid_r <= 1'b0;
      floor_r <= FLOOR_RST;
      subst_r <= SUBST_RST;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      ovf_r <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          CFG_ERROR_FLOOR: floor_r <= cfg_wdata;
          CFG_ERROR_SUBST: subst_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      z_r <= in_tdata[COORD_W-1:0];
      t_r <= in_tdata[2*COORD_W-1:COORD_W];
      last_r <= in_tlast;
      e2_r <= (2*ERR_W)'(e_eff) * (2*ERR_W)'(e_eff);
    end
    idx_r <= idx_nxt;
    sw_r <= sw_nxt;
    swz_r <= swz_nxt;
    swt_r <= swt_nxt;
    szz_r <= szz_nxt;
    szt_r <= szt_nxt;
    tmp_r <= tmp_nxt;
    zm_r <= zm_nxt;
    tm_r <= tm_nxt;
    div_neg_r <= div_neg_nxt;
    icpt_r <= icpt_nxt;
    slope_r <= slope_nxt;
    stat_r <= stat_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cnt_r[PTR_W-1:0]] <= {div_quo[W_W-1:0], t_r, z_r};
    end
    rd_q_r <= mem[idx_r];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;

  `WLF_ASSERT_ALWAYS(a_cnt_bound, cnt_r <= CNT_W'(MAX_POINTS), "point count beyond store depth")
  `WLF_ASSERT_IMPL(a_ovf_full, ovf_r, cnt_r == CNT_W'(MAX_POINTS), "overflow flag with store not full")
  `WLF_ASSERT_NEXT(a_accept_busy, accept, state_r != S_IDLE, "accepted transaction left no work")
  `WLF_ASSERT_NEXT(a_out_hold, (state_r == S_OUT) && out_valid_r && !out_tready, state_r == S_OUT, "fit result overwrote a waiting result")
  `WLF_ASSERT_NEXT(a_out_stable, out_valid_r && !out_tready, out_valid_r && $stable(out_data_r), "waiting result changed")

endmodule
